// ===== design/ssnf_pkg.sv =====
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared constants, codes and types of the next-fit object slot allocator.
// ----------------------------------------------------------------------------
package ssnf_pkg;

  // Slot pool size default, record count and field widths
  localparam int unsigned SLOT_COUNT_DEF = 40;
  localparam int unsigned REC_COUNT      = 40;
  localparam int unsigned REC_AW         = 6;
  localparam int unsigned SLOT_W         = 6;
  localparam int unsigned TILE_W         = 7;

  // Item kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // Layout codes
  localparam logic [1:0] LAYOUT_ONE    = 2'd0;
  localparam logic [1:0] LAYOUT_PAIR_A = 2'd1;
  localparam logic [1:0] LAYOUT_PAIR_B = 2'd2;
  localparam logic [1:0] LAYOUT_FOUR   = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

  // One object record as kept in the record memory
  typedef struct packed {
    logic                    busy;
    logic [1:0]              layout;
    logic [3:0][SLOT_W-1:0]  slots;
  } rec_entry_t;

  // One result item
  typedef struct packed {
    logic [1:0]              status;
    logic [REC_AW-1:0]       record_out;
    logic [2:0]              slot_count;
    logic [3:0][SLOT_W-1:0]  slot;
    logic [3:0][TILE_W-1:0]  tile;
  } rsp_t;

  // Number of slots a layout needs
  function automatic logic [2:0] need_of(input logic [1:0] layout);
    logic [2:0] n;
    case (layout) inside
      LAYOUT_ONE:                   n = 3'd1;
      LAYOUT_PAIR_A, LAYOUT_PAIR_B: n = 3'd2;
      LAYOUT_FOUR:                  n = 3'd4;
      default:                      n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// ===== design/ssnf_if.sv =====
// ----------------------------------------------------------------------------
// ssnf_if
// Request and response channels of the slot allocator, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssnf_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] layout;
  logic [5:0] base_tile;
  logic [5:0] record_id;

  modport source (output valid, kind, layout, base_tile, record_id, input ready);
  modport sink   (input valid, kind, layout, base_tile, record_id, output ready);
endinterface

interface ssnf_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] record_out;
  logic [2:0] slot_count;
  logic [5:0] slot_a;
  logic [5:0] slot_b;
  logic [5:0] slot_c;
  logic [5:0] slot_d;
  logic [6:0] tile_a;
  logic [6:0] tile_b;
  logic [6:0] tile_c;
  logic [6:0] tile_d;

  modport source (output valid, status, record_out, slot_count, slot_a, slot_b, slot_c,
                  slot_d, tile_a, tile_b, tile_c, tile_d, input ready);
  modport sink   (input valid, status, record_out, slot_count, slot_a, slot_b, slot_c,
                  slot_d, tile_a, tile_b, tile_c, tile_d, output ready);
endinterface

// ===== design/sprite_slot_next_fit_allocator_top.sv =====
// ----------------------------------------------------------------------------
// sprite_slot_next_fit_allocator_top
// Next-fit allocator of object slots and object records.
// ----------------------------------------------------------------------------
// One item is worked at a time; the sequencer makes one read per cycle into a
// slot memory and a record memory. After reset a clearing pass over both
// memories runs before the first request is taken. A free steps through
// accept, record read, one write per released slot and reply; a free of an
// unused record skips the slot writes, and one of a record id past the range
// goes from accept straight to reply. An allocate rejected as full also goes
// straight to reply; otherwise it steps through accept, slot scan (at most
// SLOT_COUNT slots visited), record scan (at most 40 records visited), one
// write per taken slot and reply. The reply stretches while the output
// register is full and not drained. A new request is taken while the previous
// result still waits in the output register.
// ----------------------------------------------------------------------------
module sprite_slot_next_fit_allocator_top #(
  parameter int unsigned SLOT_COUNT = ssnf_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ssnf_req_if.sink   req,
  ssnf_rsp_if.source rsp
);

  logic           res_valid;
  logic           res_ready;
  ssnf_pkg::rsp_t res;

  ssnf_core #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ssnf_rsp_reg u_rsp_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp       (rsp)
  );

endmodule

// ===== design/ssnf_core.sv =====
// ----------------------------------------------------------------------------
// ssnf_core
// Sequencer with the slot busy memory and the record memory. Scans both
// memories next-fit with one read per cycle, then writes back the changes.
// ----------------------------------------------------------------------------
module ssnf_core #(
  parameter int unsigned SLOT_COUNT = ssnf_pkg::SLOT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ssnf_req_if.sink       req,
  output logic           res_valid,
  input  logic           res_ready,
  output ssnf_pkg::rsp_t res
);

  localparam int unsigned SAW   = $clog2(SLOT_COUNT);
  localparam int unsigned CW    = $clog2(SLOT_COUNT + 1);
  localparam int unsigned RAW   = ssnf_pkg::REC_AW;
  localparam int unsigned CLR_N = (SLOT_COUNT > ssnf_pkg::REC_COUNT) ?
                                  SLOT_COUNT : ssnf_pkg::REC_COUNT;
  localparam int unsigned CLRW  = $clog2(CLR_N);
  localparam int unsigned IW    = $clog2(CLR_N + 1);

  typedef enum logic [7:0] {
    ST_CLEAR   = 8'b0000_0001,
    ST_IDLE    = 8'b0000_0010,
    ST_SSCAN   = 8'b0000_0100,
    ST_RSCAN   = 8'b0000_1000,
    ST_COMMIT  = 8'b0001_0000,
    ST_FREAD   = 8'b0010_0000,
    ST_RELEASE = 8'b0100_0000,
    ST_REPLY   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  // Memories
  logic                 slot_mem [SLOT_COUNT];
  ssnf_pkg::rec_entry_t rec_mem  [ssnf_pkg::REC_COUNT];

  logic                 s_we, s_wdata, s_rdata;
  logic [SAW-1:0]       s_waddr, s_raddr, s_addr_q;
  logic                 r_we;
  logic [RAW-1:0]       r_waddr, r_raddr, r_addr_q;
  ssnf_pkg::rec_entry_t r_wdata, r_rdata;

  // Control and working registers
  logic [CLRW-1:0]            clr_cnt;
  logic [CW-1:0]              busy_count;
  logic [SAW-1:0]             slot_hint;
  logic [RAW-1:0]             rec_hint;
  logic [1:0]                 layout_q;
  logic [5:0]                 base_q;
  logic [5:0]                 rid_q;
  logic [2:0]                 need;
  logic [2:0]                 n;
  logic [3:0][SAW-1:0]        got;
  logic [RAW-1:0]             rec_sel;
  logic [3:0][5:0]            slots_q;
  logic [1:0]                 wcnt;
  logic [SAW-1:0]             s_ptr;
  logic [RAW-1:0]             r_ptr;
  logic [IW-1:0]              issued;
  logic                       pend;

  // Combinational helpers
  logic                       accept;
  logic [2:0]                 req_need;
  logic                       req_full;
  logic                       req_rid_ok;
  logic                       s_hit, s_found, s_issue, s_exhaust;
  logic [2:0]                 n_plus;
  logic                       r_hit, r_issue, r_exhaust;
  logic                       w_last;
  logic [SAW-1:0]             last_slot;
  logic [5:0]                 rel_s;
  logic [3:0][5:0]            alloc_slot, rel_slot;
  logic [3:0][6:0]            alloc_tile;
  ssnf_pkg::rsp_t             res_start;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign req_need   = ssnf_pkg::need_of(req.layout);
  assign req_full   = ((CW+1)'(busy_count) + (CW+1)'(req_need)) > (CW+1)'(SLOT_COUNT);
  assign req_rid_ok = req.record_id < 6'(ssnf_pkg::REC_COUNT);

  assign s_hit     = pend && !s_rdata && (n < need);
  assign n_plus    = n + 3'(s_hit);
  assign s_found   = (n_plus == need);
  assign s_issue   = (issued != IW'(SLOT_COUNT));
  assign s_exhaust = !s_issue && !pend;

  assign r_hit     = pend && !r_rdata.busy;
  assign r_issue   = (issued != IW'(ssnf_pkg::REC_COUNT));
  assign r_exhaust = !r_issue && !pend;

  assign w_last    = ((3'(wcnt) + 3'd1) == need);
  assign last_slot = got[wcnt];
  assign rel_s     = slots_q[wcnt];
  assign res_valid = (state == ST_REPLY);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      alloc_slot[k] = (3'(k) < need) ? 6'(got[k]) : 6'd0;
      rel_slot[k]   = (3'(k) < need) ? slots_q[k] : 6'd0;
      alloc_tile[k] = (3'(k) < need) ? 7'(base_q) + 7'(k) : 7'd0;
    end
  end

  // Preset the error reply; a finished item overwrites it
  always_comb begin
    res_start = '0;
    if (req.kind == ssnf_pkg::KIND_ALLOC) begin
      res_start.status = ssnf_pkg::STATUS_FULL;
    end else begin
      res_start.status     = ssnf_pkg::STATUS_BAD_FREE;
      res_start.record_out = req.record_id;
    end
  end

  // Memory port control; the sequencer never uses a read made in the cycle that
  // writes the same entry, so no forwarding path is needed
  always_comb begin
    s_we    = 1'b0;
    s_waddr = got[wcnt];
    s_wdata = 1'b0;
    s_raddr = s_ptr;
    r_we    = 1'b0;
    r_waddr = rec_sel;
    r_wdata = r_rdata;
    r_raddr = r_ptr;
    unique case (state)
      ST_CLEAR: begin
        s_we    = ({1'b0, clr_cnt} < (CLRW+1)'(SLOT_COUNT));
        s_waddr = clr_cnt[SAW-1:0];
        r_we    = ({1'b0, clr_cnt} < (CLRW+1)'(ssnf_pkg::REC_COUNT));
        r_waddr = clr_cnt[RAW-1:0];
        r_wdata = '0;
      end
      ST_IDLE: begin
        r_raddr = req.record_id[RAW-1:0];
      end
      ST_COMMIT: begin
        s_we           = 1'b1;
        s_wdata        = 1'b1;
        r_we           = (wcnt == 2'd0);
        r_wdata.busy   = 1'b1;
        r_wdata.layout = layout_q;
        r_wdata.slots  = alloc_slot;
      end
      ST_FREAD: begin
        r_we         = r_rdata.busy;
        r_waddr      = rid_q[RAW-1:0];
        r_wdata.busy = 1'b0;
      end
      ST_RELEASE: begin
        s_we    = ({1'b0, rel_s} < 7'(SLOT_COUNT));
        s_waddr = rel_s[SAW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    s_rdata  <= slot_mem[s_raddr];
    s_addr_q <= s_raddr;
  end

  always_ff @(posedge clk) begin
    if (r_we) rec_mem[r_waddr] <= r_wdata;
    r_rdata  <= rec_mem[r_raddr];
    r_addr_q <= r_raddr;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:   if (clr_cnt == CLRW'(CLR_N - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == ssnf_pkg::KIND_ALLOC) begin
            state_next = req_full ? ST_REPLY : ST_SSCAN;
          end else begin
            state_next = req_rid_ok ? ST_FREAD : ST_REPLY;
          end
        end
      end
      ST_SSCAN: begin
        if (s_found)        state_next = ST_RSCAN;
        else if (s_exhaust) state_next = ST_REPLY;
      end
      ST_RSCAN: begin
        if (r_hit)          state_next = ST_COMMIT;
        else if (r_exhaust) state_next = ST_REPLY;
      end
      ST_COMMIT:  if (w_last) state_next = ST_REPLY;
      ST_FREAD:   state_next = r_rdata.busy ? ST_RELEASE : ST_REPLY;
      ST_RELEASE: if (w_last) state_next = ST_REPLY;
      ST_REPLY:   if (res_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      busy_count <= '0;
      slot_hint  <= '0;
      rec_hint   <= '0;
      pend       <= 1'b0;
      issued     <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            layout_q <= req.layout;
            base_q   <= req.base_tile;
            rid_q    <= req.record_id;
            need     <= req_need;
            n        <= 3'd0;
            issued   <= '0;
            pend     <= 1'b0;
            s_ptr    <= slot_hint;
            wcnt     <= 2'd0;
            res      <= res_start;
          end
        end
        ST_SSCAN: begin
          if (s_hit) begin
            got[n[1:0]] <= s_addr_q;
            n           <= n_plus;
          end
          // Slots in hand: restart the shared counter for the record scan
          if (s_found) begin
            r_ptr  <= rec_hint;
            issued <= '0;
            pend   <= 1'b0;
          end else begin
            if (s_issue) begin
              s_ptr  <= (s_ptr == SAW'(SLOT_COUNT - 1)) ? '0 : s_ptr + 1'b1;
              issued <= issued + 1'b1;
            end
            pend <= s_issue;
          end
        end
        ST_RSCAN: begin
          if (r_issue) begin
            r_ptr  <= (r_ptr == RAW'(ssnf_pkg::REC_COUNT - 1)) ? '0 : r_ptr + 1'b1;
            issued <= issued + 1'b1;
          end
          pend <= r_issue;
          if (r_hit) begin
            rec_sel <= r_addr_q;
            wcnt    <= 2'd0;
          end
        end
        ST_COMMIT: begin
          wcnt <= wcnt + 1'b1;
          if (w_last) begin
            slot_hint  <= (last_slot == SAW'(SLOT_COUNT - 1)) ? '0 : last_slot + 1'b1;
            rec_hint   <= (rec_sel == RAW'(ssnf_pkg::REC_COUNT - 1)) ? '0 : rec_sel + 1'b1;
            busy_count <= busy_count + CW'(need);
            res.status     <= ssnf_pkg::STATUS_DONE;
            res.record_out <= 6'(rec_sel);
            res.slot_count <= need;
            res.slot       <= alloc_slot;
            res.tile       <= alloc_tile;
          end
        end
        ST_FREAD: begin
          need    <= ssnf_pkg::need_of(r_rdata.layout);
          slots_q <= r_rdata.slots;
          wcnt    <= 2'd0;
        end
        ST_RELEASE: begin
          wcnt <= wcnt + 1'b1;
          if (w_last) begin
            busy_count <= (busy_count >= CW'(need)) ? busy_count - CW'(need) : '0;
            rec_hint   <= rid_q[RAW-1:0];
            res.status     <= ssnf_pkg::STATUS_DONE;
            res.record_out <= rid_q;
            res.slot_count <= need;
            res.slot       <= rel_slot;
          end
        end
        ST_REPLY: ;
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    busy_count <= CW'(SLOT_COUNT))
    else $error("busy count exceeds slot pool");

  a_hint_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, slot_hint} < (SAW+1)'(SLOT_COUNT)) &&
    (rec_hint < RAW'(ssnf_pkg::REC_COUNT)))
    else $error("hint out of range");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted item did not start");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_COMMIT) || (state == ST_RELEASE)) |-> ({1'b0, wcnt} < need))
    else $error("write-back runs past the slot need");
`endif

endmodule

// ===== design/ssnf_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// ssnf_rsp_reg
// Output register: holds one finished result until the response transfer.
// ----------------------------------------------------------------------------
module ssnf_rsp_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  ssnf_pkg::rsp_t res,
  ssnf_rsp_if.source     rsp
);

  logic           full;
  ssnf_pkg::rsp_t data;

  assign res_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (res_valid && res_ready) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) data <= res;
  end

  assign rsp.valid      = full;
  assign rsp.status     = data.status;
  assign rsp.record_out = data.record_out;
  assign rsp.slot_count = data.slot_count;
  assign rsp.slot_a     = data.slot[0];
  assign rsp.slot_b     = data.slot[1];
  assign rsp.slot_c     = data.slot[2];
  assign rsp.slot_d     = data.slot[3];
  assign rsp.tile_a     = data.tile[0];
  assign rsp.tile_b     = data.tile[1];
  assign rsp.tile_c     = data.tile[2];
  assign rsp.tile_d     = data.tile[3];

endmodule
